// File: sv/wte_pkg.sv
// Shared types, constants and width helpers for the windowed throughput estimator.
`timescale 1ns / 1ps

package wte_pkg;

    localparam int DATA_W     = 32;
    localparam int EST_W      = 48;
    localparam int CASE_W     = 2;
    localparam int WINDOW_DEF = 5;

    // 8 * 1e6 = 15625 << 9
    localparam int MUL_K      = 15625;
    localparam int MUL_K_W    = 14;
    localparam int MUL_SHIFT  = 9;

    localparam logic [CASE_W-1:0] CASE_EMPTY   = 2'd0;
    localparam logic [CASE_W-1:0] CASE_PARTIAL = 2'd1;
    localparam logic [CASE_W-1:0] CASE_FULL    = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] segment_bytes;
        logic [DATA_W-1:0] transfer_time_us;
    } in_t;

    typedef struct packed {
        logic [EST_W-1:0]  estimate_bps;
        logic [CASE_W-1:0] window_case;
        logic              saturated;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    typedef struct packed {
        logic accept;
        logic mul_load;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic out_stall;
    } status_t;

    function automatic int sum_width(input int window);
        return DATA_W + $clog2(window);
    endfunction

    function automatic int prod_width(input int window);
        return sum_width(window) + MUL_K_W + MUL_SHIFT;
    endfunction

endpackage

// File: sv/wte_ctrl.sv
// Controller state machine: intake, multiply, divide iterations and result hand-off.
`timescale 1ns / 1ps

module wte_ctrl #(
    parameter int WINDOW = wte_pkg::WINDOW_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output wte_pkg::cmd_t    cmd,
    input  wte_pkg::status_t status
);
    import wte_pkg::*;

    localparam int PROD_W = prod_width(WINDOW);
    localparam int CNT_W  = $clog2(PROD_W);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_load = 1'b1;
                cnt_next     = CNT_W'(PROD_W - 1);
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!status.out_stall) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: sv/wte_datapath.sv
// Datapath: segment ring, running sums, constant multiply, radix-2 divider, output register.
`timescale 1ns / 1ps

module wte_datapath #(
    parameter int WINDOW = wte_pkg::WINDOW_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  wte_pkg::in_t      s_data,
    input  wte_pkg::cmd_t     cmd,
    output wte_pkg::status_t  status,
    output logic              m_valid,
    input  logic              m_ready,
    output wte_pkg::out_t     m_data
);
    import wte_pkg::*;

    localparam int SUM_W  = sum_width(WINDOW);
    localparam int PROD_W = prod_width(WINDOW);
    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);

    logic [DATA_W-1:0] size_ring_reg [WINDOW];
    logic [DATA_W-1:0] time_ring_reg [WINDOW];

    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  byte_sum_reg, byte_sum_next;
    logic [SUM_W-1:0]  time_sum_reg, time_sum_next;
    logic [CASE_W-1:0] case_reg, case_next;

    logic [PROD_W-1:0] quo_reg;
    logic [SUM_W-1:0]  rem_reg;
    logic [SUM_W:0]    rem_shift;
    logic [SUM_W:0]    rem_diff;
    logic              rem_ge;
    logic [SUM_W+MUL_K_W-1:0] product;

    logic              full;
    logic [DATA_W-1:0] old_bytes;
    logic [DATA_W-1:0] old_time;

    logic              m_valid_reg;
    out_t              m_data_reg;
    logic              sat;

    assign full      = (count_reg == CNT_W'(WINDOW));
    assign old_bytes = full ? size_ring_reg[ptr_reg] : '0;
    assign old_time  = full ? time_ring_reg[ptr_reg] : '0;

    always_comb begin
        byte_sum_next = byte_sum_reg - SUM_W'(old_bytes) + SUM_W'(s_data.segment_bytes);
        time_sum_next = time_sum_reg - SUM_W'(old_time) + SUM_W'(s_data.transfer_time_us);
        count_next    = full ? count_reg : count_reg + 1'b1;
        ptr_next      = (ptr_reg == PTR_W'(WINDOW - 1)) ? '0 : ptr_reg + 1'b1;
        case_next     = (count_next == CNT_W'(WINDOW)) ? CASE_FULL : CASE_PARTIAL;
    end

    assign product   = byte_sum_reg * MUL_K_W'(MUL_K);
    assign rem_shift = {rem_reg, quo_reg[PROD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, time_sum_reg};
    assign rem_ge    = !rem_diff[SUM_W];

    assign sat = (time_sum_reg == '0) || (quo_reg[PROD_W-1:EST_W] != '0);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            size_ring_reg[ptr_reg] <= s_data.segment_bytes;
            time_ring_reg[ptr_reg] <= s_data.transfer_time_us;
            case_reg               <= case_next;
        end
        if (cmd.mul_load) begin
            quo_reg <= {product, MUL_SHIFT'(0)};
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            quo_reg <= {quo_reg[PROD_W-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_diff[SUM_W-1:0] : rem_shift[SUM_W-1:0];
        end
        if (cmd.out_load) begin
            m_data_reg.estimate_bps <= sat ? {EST_W{1'b1}} : quo_reg[EST_W-1:0];
            m_data_reg.window_case  <= case_reg;
            m_data_reg.saturated    <= sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg      <= '0;
            count_reg    <= '0;
            byte_sum_reg <= '0;
            time_sum_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.accept) begin
                ptr_reg      <= ptr_next;
                count_reg    <= count_next;
                byte_sum_reg <= byte_sum_next;
                time_sum_reg <= time_sum_next;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_stall = m_valid_reg && !m_ready;
    assign m_valid          = m_valid_reg;
    assign m_data           = m_data_reg;

endmodule

// File: sv/windowed_throughput_estimator_top.sv
// Top level of the windowed throughput estimator.
`timescale 1ns / 1ps

// Each transfer on s_ carries one finished segment (bytes, microseconds); the block keeps the
// last WINDOW segments and returns floor(8e6 * byte_sum / time_sum) in bits per second, saturated
// to 2^48-1 with the flag set when the time sum is zero or the quotient needs more than 48 bits.
// An item passes from intake through the constant multiply and the bit-per-cycle restoring
// divider, which forms PROD_W quotient bits, where PROD_W = 32 + clog2(WINDOW) + 23, and
// then the result is loaded into the output register. Items are handled one at a time; s_ready
// is high only while the engine is free, so a new item is not taken before the last one is in
// the output register. The next item is taken while a finished result still waits on m_; its
// own result then holds in the engine until the waiting one is taken.

module windowed_throughput_estimator_top #(
    parameter int WINDOW = wte_pkg::WINDOW_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  wte_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output wte_pkg::out_t m_data
);
    import wte_pkg::*;

    cmd_t    cmd;
    status_t status;

    wte_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    wte_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef NO_ASSERTIONS
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("intake open while an item is in flight");

    a_result_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.out_load))
        else $error("result appeared without an output load");

    a_case_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.window_case == CASE_PARTIAL || m_data.window_case == CASE_FULL))
        else $error("result carries an empty-window case");
`endif

endmodule

// File: dv/tb.sv
// Self-checking testbench for the windowed throughput estimator: directed, random and stall traffic.
`timescale 1ns / 1ps

module tb;
    import wte_pkg::*;

    localparam int          WIN          = WINDOW_DEF;
    localparam logic [63:0] BIT_SCALE    = 64'd8_000_000;
    localparam logic [63:0] EST_LIMIT    = {16'b0, {EST_W{1'b1}}};
    localparam int          STUCK_LIMIT  = 4000;
    localparam int          DRAIN_CYCLES = 80;
    localparam int          LONG_HOLD    = 400;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    logic [DATA_W-1:0] bytes_hist [WIN];
    logic [DATA_W-1:0] time_hist [WIN];
    logic [63:0]       bytes_total;
    logic [63:0]       time_total;
    int unsigned       held_count;
    int unsigned       next_slot;

    out_t pending_estimates [$];
    int   error_count;
    int   stuck_cycles;
    int   hold_cycles;
    bit   src_idle_on;
    bit   sink_idle_on;

    windowed_throughput_estimator_top #(
        .WINDOW(WIN)
    ) u_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic out_t advance_window(input logic [DATA_W-1:0] seg_bytes,
                                            input logic [DATA_W-1:0] seg_time);
        out_t        est;
        logic [63:0] quotient;
        if (held_count >= WIN) begin
            bytes_total -= bytes_hist[next_slot];
            time_total  -= time_hist[next_slot];
        end else begin
            held_count++;
        end
        bytes_hist[next_slot] = seg_bytes;
        time_hist[next_slot]  = seg_time;
        bytes_total += seg_bytes;
        time_total  += seg_time;
        next_slot = (next_slot + 1) % WIN;
        est.window_case = (held_count >= WIN) ? CASE_FULL : CASE_PARTIAL;
        if (time_total == 0) begin
            est.estimate_bps = '1;
            est.saturated    = 1'b1;
        end else begin
            quotient = (bytes_total * BIT_SCALE) / time_total;
            if (quotient > EST_LIMIT) begin
                est.estimate_bps = '1;
                est.saturated    = 1'b1;
            end else begin
                est.estimate_bps = quotient[EST_W-1:0];
                est.saturated    = 1'b0;
            end
        end
        return est;
    endfunction

    function automatic logic [DATA_W-1:0] rand_field();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            2: v = $urandom_range(1, 255);
            3: v = 32'd1 << $urandom_range(0, DATA_W - 1);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_segment(input logic [DATA_W-1:0] seg_bytes,
                                input logic [DATA_W-1:0] seg_time);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid               <= 1'b1;
        s_data.segment_bytes    <= seg_bytes;
        s_data.transfer_time_us <= seg_time;
        do @(posedge aclk); while (!s_ready);
        pending_estimates.push_back(advance_window(seg_bytes, seg_time));
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (pending_estimates.size() != 0) @(posedge aclk);
    endtask

    task automatic clear_window();
        repeat (WIN) send_segment('0, '0);
    endtask

    task automatic test_directed_cases();
        send_segment('0, '0);
        send_segment('1, 32'd1);
        send_segment('0, 32'd5);
        send_segment(32'd1, '1);
        send_segment('1, '1);
        clear_window();
        send_segment('0, 32'd1);
        send_segment(32'd1, 32'd8_000_000);
        clear_window();
        send_segment(32'd35_184_372, 32'd1);
        send_segment(32'd1, '0);
        repeat (WIN) send_segment('1, '1);
        send_segment(32'h8000_0000, 32'h0000_0001);
    endtask

    task automatic test_random_segments(input int count);
        repeat (count) begin
            if ($urandom_range(0, 3) == 0)
                send_segment($urandom, $urandom_range(0, 3));
            else
                send_segment(rand_field(), rand_field());
        end
    endtask

    task automatic test_input_backpressure();
        src_idle_on = 1'b0;
        hold_cycles = LONG_HOLD;
        test_random_segments(12);
        src_idle_on = 1'b1;
    endtask

    task automatic test_sender_drain_pause();
        test_random_segments(10);
        wait_results_drained();
        test_random_segments(10);
    endtask

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : check_results
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_estimates.size() == 0) begin
                $error("unexpected result: estimate_bps %0d window_case %0d saturated %0d",
                       m_data.estimate_bps, m_data.window_case, m_data.saturated);
                error_count++;
            end else begin
                want = pending_estimates.pop_front();
                if (m_data.estimate_bps !== want.estimate_bps) begin
                    $error("estimate_bps expected %0d actual %0d",
                           want.estimate_bps, m_data.estimate_bps);
                    error_count++;
                end
                if (m_data.window_case !== want.window_case) begin
                    $error("window_case expected %0d actual %0d",
                           want.window_case, m_data.window_case);
                    error_count++;
                end
                if (m_data.saturated !== want.saturated) begin
                    $error("saturated expected %0d actual %0d",
                           want.saturated, m_data.saturated);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_data       <= '0;
        error_count  = 0;
        stuck_cycles = 0;
        hold_cycles  = 0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        bytes_total  = '0;
        time_total   = '0;
        held_count   = 0;
        next_slot    = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_random_segments(400);
        test_input_backpressure();
        test_sender_drain_pause();
        test_random_segments(150);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        test_random_segments(150);

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
